// File: sv/jtf_pkg.sv
// shared types, codes and tables of the japanese text fold block
package jtf_pkg;

    // depth of the queue between classifier and sequencer
    localparam int QUEUE_DEPTH = 4;

    // configuration register indexes
    localparam logic CFG_KANA = 1'b0;
    localparam logic CFG_CAP  = 1'b1;

    // request kinds from the classifier
    localparam logic [1:0] K_NONE  = 2'd0;
    localparam logic [1:0] K_SPACE = 2'd1;
    localparam logic [1:0] K_MARK  = 2'd2;
    localparam logic [1:0] K_PUSH  = 2'd3;

    // run of up to four characters to be written
    typedef struct packed {
        logic [2:0]       cnt;
        logic [3:0][20:0] cp;
    } t_run;

    // classified request handed to the sequencer
    typedef struct packed {
        logic [1:0] kind;
        logic       semi;
        logic       last;
        t_run       run;
    } t_desc;

    // half-width katakana to full-width forms
    localparam logic [15:0] HW_MAP [63] = '{
        16'h3002, 16'h300C, 16'h300D, 16'h3001, 16'h30FB, 16'h30F2, 16'h30A1, 16'h30A3,
        16'h30A5, 16'h30A7, 16'h30A9, 16'h30E3, 16'h30E5, 16'h30E7, 16'h30C3, 16'h30FC,
        16'h30A2, 16'h30A4, 16'h30A6, 16'h30A8, 16'h30AA, 16'h30AB, 16'h30AD, 16'h30AF,
        16'h30B1, 16'h30B3, 16'h30B5, 16'h30B7, 16'h30B9, 16'h30BB, 16'h30BD, 16'h30BF,
        16'h30C1, 16'h30C4, 16'h30C6, 16'h30C8, 16'h30CA, 16'h30CB, 16'h30CC, 16'h30CD,
        16'h30CE, 16'h30CF, 16'h30D2, 16'h30D5, 16'h30D8, 16'h30DB, 16'h30DE, 16'h30DF,
        16'h30E0, 16'h30E1, 16'h30E2, 16'h30E4, 16'h30E6, 16'h30E8, 16'h30E9, 16'h30EA,
        16'h30EB, 16'h30EC, 16'h30ED, 16'h30EF, 16'h30F3, 16'h0000, 16'h0000
    };

    // build a run from up to four 16-bit codes
    function automatic t_run mk_run(input logic [2:0] cnt, input logic [15:0] a,
                                    input logic [15:0] b, input logic [15:0] c,
                                    input logic [15:0] d);
        t_run r;
        r.cnt   = cnt;
        r.cp[0] = {5'd0, a};
        r.cp[1] = {5'd0, b};
        r.cp[2] = {5'd0, c};
        r.cp[3] = {5'd0, d};
        return r;
    endfunction

    // enclosed company signs
    function automatic t_run company_run(input logic [2:0] sel);
        t_run r;
        case (sel)
            3'd0:    r = mk_run(3'd4, 16'h682A, 16'h5F0F, 16'h4F1A, 16'h793E);
            3'd1:    r = mk_run(3'd4, 16'h6709, 16'h9650, 16'h4F1A, 16'h793E);
            3'd2:    r = mk_run(3'd4, 16'h793E, 16'h56E3, 16'h6CD5, 16'h4EBA);
            3'd3:    r = mk_run(3'd4, 16'h5408, 16'h540D, 16'h4F1A, 16'h793E);
            default: r = mk_run(3'd4, 16'h8CA1, 16'h56E3, 16'h6CD5, 16'h4EBA);
        endcase
        return r;
    endfunction

    // roman numerals as lower-case letters
    function automatic t_run roman_run(input logic [3:0] sel);
        t_run r;
        case (sel)
            4'd0:    r = mk_run(3'd1, 16'h69, 16'h00, 16'h00, 16'h00);
            4'd1:    r = mk_run(3'd2, 16'h69, 16'h69, 16'h00, 16'h00);
            4'd2:    r = mk_run(3'd3, 16'h69, 16'h69, 16'h69, 16'h00);
            4'd3:    r = mk_run(3'd2, 16'h69, 16'h76, 16'h00, 16'h00);
            4'd4:    r = mk_run(3'd1, 16'h76, 16'h00, 16'h00, 16'h00);
            4'd5:    r = mk_run(3'd2, 16'h76, 16'h69, 16'h00, 16'h00);
            4'd6:    r = mk_run(3'd3, 16'h76, 16'h69, 16'h69, 16'h00);
            4'd7:    r = mk_run(3'd4, 16'h76, 16'h69, 16'h69, 16'h69);
            4'd8:    r = mk_run(3'd2, 16'h69, 16'h78, 16'h00, 16'h00);
            4'd9:    r = mk_run(3'd1, 16'h78, 16'h00, 16'h00, 16'h00);
            4'd10:   r = mk_run(3'd2, 16'h78, 16'h69, 16'h00, 16'h00);
            4'd11:   r = mk_run(3'd3, 16'h78, 16'h69, 16'h69, 16'h00);
            4'd12:   r = mk_run(3'd1, 16'h6C, 16'h00, 16'h00, 16'h00);
            4'd13:   r = mk_run(3'd1, 16'h63, 16'h00, 16'h00, 16'h00);
            4'd14:   r = mk_run(3'd1, 16'h64, 16'h00, 16'h00, 16'h00);
            default: r = mk_run(3'd1, 16'h6D, 16'h00, 16'h00, 16'h00);
        endcase
        return r;
    endfunction

endpackage

// File: sv/jtf_if.sv
// request channels of the japanese text fold block
interface jtf_in_if;
    logic        valid;
    logic        ready;
    logic [20:0] in_code_point;
    logic        in_has_char;
    logic        end_of_text;
    modport source (output valid, in_code_point, in_has_char, end_of_text, input ready);
    modport sink   (input valid, in_code_point, in_has_char, end_of_text, output ready);
endinterface

interface jtf_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] out_code_point;
    logic        out_has_char;
    logic        last_of_text;
    modport source (output valid, out_code_point, out_has_char, last_of_text, input ready);
    modport sink   (input valid, out_code_point, out_has_char, last_of_text, output ready);
endinterface

// File: sv/japanese_text_fold.sv
// top level of the japanese text fold block
//
//  channel   dir  handshake      payload
//  s_in      in   valid/ready    in_code_point, in_has_char, end_of_text
//  m_out     out  valid/ready    out_code_point, out_has_char, last_of_text
//  cfg       in   i_cfg_we       i_cfg_index, i_cfg_data
//
// the sequencer handles the characters of a run one at a time, sends an
// owed space out ahead of the character that follows it, and handles an end
// of text request as a step of its own
// reset empties the queue and clears the held character and byte count
// the classifier stalls only when the queue is full; the sequencer stalls
// while the result register holds a request that is not taken
module japanese_text_fold
    import jtf_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    jtf_in_if.sink      s_in,
    jtf_out_if.source   m_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic        r_kana;
    logic [15:0] r_cap;
    logic        q_wr;
    t_desc       q_wdata;
    logic        q_full;
    logic        q_valid;
    logic        q_pop;
    t_desc       q_rdata;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kana <= 1'b1;
            r_cap  <= 16'hFFFF;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KANA: r_kana <= i_cfg_data[0];
                CFG_CAP:  r_cap  <= i_cfg_data;
                default:  r_cap  <= r_cap;
            endcase
        end
    end

    jtf_front u_front (
        .s_in    (s_in),
        .i_kana  (r_kana),
        .i_full  (q_full),
        .o_wr    (q_wr),
        .o_desc  (q_wdata)
    );

    jtf_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_rdata (q_rdata)
    );

    jtf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cap   (r_cap),
        .i_valid (q_valid),
        .i_desc  (q_rdata),
        .o_pop   (q_pop),
        .m_out   (m_out)
    );

endmodule

// File: sv/jtf_front.sv
// classifier: maps one input codepoint to a run, a mark, a space or nothing
module jtf_front
    import jtf_pkg::*;
(
    jtf_in_if.sink s_in,
    input  logic  i_kana,
    input  logic  i_full,
    output logic  o_wr,
    output t_desc o_desc
);

    // lower-case latin-1 and extended-a letters
    function automatic logic [8:0] lower_latin(input logic [8:0] c);
        logic [8:0] r;
        r = c;
        if (c inside {[9'h41:9'h5A]}) r = c + 9'd32;
        else if (c < 9'hC0) r = c;
        else if (c <= 9'hDE) r = (c == 9'hD7) ? c : c + 9'd32;
        else if (c == 9'h178) r = 9'hFF;
        else if (c inside {[9'h100:9'h137], [9'h14A:9'h177]}) r = c | 9'd1;
        else if (c inside {[9'h139:9'h148], [9'h179:9'h17E]}) r = c[0] ? c + 9'd1 : c;
        return r;
    endfunction

    logic [20:0] c;
    logic [20:0] f;
    logic [20:0] g;
    logic        fall;
    logic [1:0]  kind;
    logic        semi;
    t_run        run;
    t_run        circ;
    logic [5:0]  off;
    logic [1:0]  ckind;
    logic [4:0]  num;
    logic [1:0]  tens;
    logic [4:0]  ones;
    logic [2:0]  p;
    logic [2:0]  csel;

    assign c = s_in.in_code_point;

    // circled, parenthesized and dotted numbers
    always_comb begin
        off = 6'(c - 21'h2460);
        if (off >= 6'd40) begin
            ckind = 2'd2;
            num   = 5'(off - 6'd40) + 5'd1;
        end else if (off >= 6'd20) begin
            ckind = 2'd1;
            num   = 5'(off - 6'd20) + 5'd1;
        end else begin
            ckind = 2'd0;
            num   = 5'(off) + 5'd1;
        end
        if (num >= 5'd20) begin
            tens = 2'd2;
            ones = num - 5'd20;
        end else if (num >= 5'd10) begin
            tens = 2'd1;
            ones = num - 5'd10;
        end else begin
            tens = 2'd0;
            ones = num;
        end
        circ = '0;
        p    = 3'd0;
        if (ckind == 2'd1) begin
            circ.cp[p[1:0]] = 21'h28;
            p = p + 3'd1;
        end
        if (tens != 2'd0) begin
            circ.cp[p[1:0]] = 21'h30 + 21'(tens);
            p = p + 3'd1;
        end
        circ.cp[p[1:0]] = 21'h30 + 21'(ones);
        p = p + 3'd1;
        if (ckind != 2'd0) begin
            circ.cp[p[1:0]] = (ckind == 2'd1) ? 21'h29 : 21'h2E;
            p = p + 3'd1;
        end
        circ.cnt = p;
    end

    // company sign select
    always_comb begin
        case (c[3:0])
            4'h1:    csel = 3'd0;
            4'h2:    csel = 3'd1;
            4'h3:    csel = 3'd2;
            4'h4:    csel = 3'd3;
            4'h6:    csel = 3'd4;
            default: csel = 3'd0;
        endcase
    end

    // classification
    always_comb begin
        kind = K_PUSH;
        semi = 1'b0;
        fall = 1'b0;
        f    = c;
        run  = '0;
        g    = c;
        if (!s_in.in_has_char) begin
            kind = K_NONE;
        end else if (c inside {21'h20, [21'h09:21'h0D], 21'h3000, 21'hA0,
                               [21'h2000:21'h200A], 21'h202F, 21'h205F}) begin
            kind = K_SPACE;
        end else if (c inside {21'h0, [21'h200B:21'h200D], 21'hFEFF}) begin
            kind = K_NONE;
        end else if (c inside {[21'hFF01:21'hFF5E]}) begin
            f    = c - 21'hFEE0;
            fall = 1'b1;
        end else if (c inside {[21'hFF61:21'hFF9F]}) begin
            if (c >= 21'hFF9E) begin
                kind = K_MARK;
                semi = (c == 21'hFF9F);
            end else begin
                f    = {5'd0, HW_MAP[6'(c - 21'hFF61)]};
                fall = 1'b1;
            end
        end else if (c inside {21'h3099, 21'h309B}) begin
            kind = K_MARK;
        end else if (c inside {21'h309A, 21'h309C}) begin
            kind = K_MARK;
            semi = 1'b1;
        end else if (c inside {21'h301C, 21'h2053}) begin
            f    = 21'h7E;
            fall = 1'b1;
        end else if (c inside {[21'h2010:21'h2015], 21'h2212}) begin
            f    = 21'h2D;
            fall = 1'b1;
        end else if (c inside {[21'h3231:21'h3234], 21'h3236}) begin
            run = company_run(csel);
        end else if (c == 21'h337F) begin
            run = company_run(3'd0);
        end else if (c inside {[21'h32A4:21'h32A8]}) begin
            run.cnt = 3'd1;
            case (c[3:0])
                4'h4:    run.cp[0] = 21'h4E0A;
                4'h5:    run.cp[0] = 21'h4E2D;
                4'h6:    run.cp[0] = 21'h4E0B;
                4'h7:    run.cp[0] = 21'h5DE6;
                default: run.cp[0] = 21'h53F3;
            endcase
        end else if (c == 21'h2116) begin
            run = mk_run(3'd2, 16'h6E, 16'h6F, 16'h00, 16'h00);
        end else if (c == 21'h2121) begin
            run = mk_run(3'd3, 16'h74, 16'h65, 16'h6C, 16'h00);
        end else if (c == 21'h24EA) begin
            f    = 21'h30;
            fall = 1'b1;
        end else if (c inside {[21'h2460:21'h249B]}) begin
            run = circ;
        end else if (c inside {[21'h2160:21'h217F]}) begin
            run = roman_run(c[3:0]);
        end else begin
            fall = 1'b1;
        end
        // folding of single characters
        if (fall) begin
            g = f;
            if (i_kana && (f inside {[21'h30A1:21'h30F6]})) g = f - 21'h60;
            if (g < 21'h180) g = {12'd0, lower_latin(g[8:0])};
            run.cnt   = 3'd1;
            run.cp[0] = g;
        end
    end

    // request into the queue
    assign s_in.ready  = !i_full;
    assign o_wr        = s_in.valid && !i_full && !(kind == K_NONE && !s_in.end_of_text);
    assign o_desc.kind = kind;
    assign o_desc.semi = semi;
    assign o_desc.last = s_in.end_of_text;
    assign o_desc.run  = run;

endmodule

// File: sv/jtf_queue.sv
// small request queue between classifier and sequencer
module jtf_queue
    import jtf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_desc i_wdata,
    output logic  o_full,
    output logic  o_valid,
    input  logic  i_pop,
    output t_desc o_rdata
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_desc          r_mem [DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;
    logic           wr_en;
    logic           rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rdata = r_mem[r_rp];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (rd_en) r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            if (wr_en && !rd_en) r_cnt <= r_cnt + 1'b1;
            else if (rd_en && !wr_en) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

// File: sv/jtf_back.sv
// sequencer: held character, space owing, byte count and result register
module jtf_back
    import jtf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_cap,
    input  logic        i_valid,
    input  t_desc       i_desc,
    output logic        o_pop,
    jtf_out_if.source   m_out
);

    // dakuten family test on the base hiragana
    function automatic logic h_row(input logic [20:0] b);
        return (b == 21'h306F) || (b == 21'h3072) || (b == 21'h3075) ||
               (b == 21'h3078) || (b == 21'h307B);
    endfunction

    function automatic logic [20:0] voice_of(input logic [20:0] c, input logic semi);
        logic [20:0] b;
        logic [20:0] r;
        b = (c >= 21'h30A1) ? c - 21'h60 : c;
        r = '0;
        if (semi) begin
            if (h_row(b)) r = c + 21'd2;
        end else if (b >= 21'h3041 && b <= 21'h3096) begin
            if (b == 21'h3046) r = c + 21'h4E;
            else if (((b inside {[21'h304B:21'h3062]}) && b[0]) ||
                     ((b inside {[21'h3064:21'h3069]}) && !b[0]) || h_row(b))
                r = c + 21'd1;
        end
        return r;
    endfunction

    function automatic logic [2:0] utf8_size(input logic [20:0] c);
        if (c < 21'h80) return 3'd1;
        if (c < 21'h800) return 3'd2;
        if (c < 21'h10000) return 3'd3;
        return 3'd4;
    endfunction

    logic [2:0]  r_idx,    n_idx;
    logic        r_emit,   n_emit;
    logic [20:0] r_held,   n_held;
    logic        r_held_v, n_held_v;
    logic        r_space,  n_space;
    logic [15:0] r_bytes,  n_bytes;
    logic        r_full,   n_full;
    logic        r_ov,     n_ov;
    logic [20:0] r_ocp,    n_ocp;
    logic        r_ohas,   n_ohas;
    logic        r_olast,  n_olast;

    logic        out_free;
    logic [2:0]  nops;
    logic [20:0] pc;
    logic [3:0]  need;
    logic        with_sp;
    logic        fail;
    logic [20:0] v;
    logic        adv;
    logic        emit;
    logic [20:0] e_cp;
    logic        e_has;
    logic        e_last;

    assign out_free = !r_ov || m_out.ready;
    assign nops     = (i_desc.kind == K_PUSH) ? i_desc.run.cnt :
                      (i_desc.kind == K_NONE) ? 3'd0 : 3'd1;
    assign pc       = i_desc.run.cp[r_idx[1:0]];
    assign with_sp  = r_space && (r_bytes != '0);
    assign need     = {1'b0, utf8_size(pc)} + {3'd0, with_sp};
    assign fail     = r_full || ({1'b0, r_bytes} + 17'(need) >= {1'b0, i_cap});
    assign v        = voice_of(r_held, i_desc.semi);

    // step of the current request
    always_comb begin
        n_idx    = r_idx;
        n_emit   = r_emit;
        n_held   = r_held;
        n_held_v = r_held_v;
        n_space  = r_space;
        n_bytes  = r_bytes;
        n_full   = r_full;
        o_pop    = 1'b0;
        adv      = 1'b0;
        emit     = 1'b0;
        e_cp     = r_held;
        e_has    = 1'b1;
        e_last   = 1'b0;
        if (out_free && i_valid) begin
            if (r_idx < nops) begin
                adv = 1'b1;
                case (i_desc.kind)
                    K_PUSH: begin
                        if (r_held_v && with_sp && !fail) begin
                            // send the held character first, then retry
                            emit     = 1'b1;
                            n_held_v = 1'b0;
                            adv      = 1'b0;
                        end else begin
                            if (r_held_v) begin
                                emit     = 1'b1;
                                e_last   = i_desc.last && fail;
                                n_held_v = 1'b0;
                            end else if (with_sp && !fail) begin
                                emit = 1'b1;
                                e_cp = 21'h20;
                            end
                            n_space = 1'b0;
                            if (fail) begin
                                n_full = 1'b1;
                            end else begin
                                n_bytes  = r_bytes + 16'(need);
                                n_held   = pc;
                                n_held_v = 1'b1;
                            end
                        end
                    end
                    K_MARK: begin
                        if (r_held_v && !r_space && !r_full && v != '0) n_held = v;
                    end
                    K_SPACE: begin
                        n_space = 1'b1;
                    end
                    default: begin
                    end
                endcase
                if (adv) n_idx = r_idx + 3'd1;
                if (adv && (r_idx + 3'd1 == nops) && !i_desc.last) o_pop = 1'b1;
            end else begin
                // end of text: flush held or give the empty result
                o_pop = 1'b1;
                if (i_desc.last) begin
                    if (r_held_v) begin
                        emit   = 1'b1;
                        e_last = 1'b1;
                    end else if (!r_emit) begin
                        emit   = 1'b1;
                        e_cp   = '0;
                        e_has  = 1'b0;
                        e_last = 1'b1;
                    end
                    n_held   = '0;
                    n_held_v = 1'b0;
                    n_space  = 1'b0;
                    n_bytes  = '0;
                    n_full   = 1'b0;
                end
            end
            n_emit = r_emit || emit;
            if (o_pop) begin
                n_idx  = '0;
                n_emit = 1'b0;
            end
        end
    end

    // result register
    always_comb begin
        n_ov    = r_ov;
        n_ocp   = r_ocp;
        n_ohas  = r_ohas;
        n_olast = r_olast;
        if (out_free) begin
            n_ov = emit;
            if (emit) begin
                n_ocp   = e_cp;
                n_ohas  = e_has;
                n_olast = e_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_emit   <= 1'b0;
            r_held   <= '0;
            r_held_v <= 1'b0;
            r_space  <= 1'b0;
            r_bytes  <= '0;
            r_full   <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_idx    <= n_idx;
            r_emit   <= n_emit;
            r_held   <= n_held;
            r_held_v <= n_held_v;
            r_space  <= n_space;
            r_bytes  <= n_bytes;
            r_full   <= n_full;
            r_ov     <= n_ov;
        end
        r_ocp   <= n_ocp;
        r_ohas  <= n_ohas;
        r_olast <= n_olast;
    end

    assign m_out.valid          = r_ov;
    assign m_out.out_code_point = r_ocp;
    assign m_out.out_has_char   = r_ohas;
    assign m_out.last_of_text   = r_olast;

endmodule

// File: sv/jtf_checker.sv
// port checks of the japanese text fold block and their binding
module jtf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [20:0] i_out_cp,
    input logic        i_out_has,
    input logic        i_out_last
);

    // a stalled request keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_cp) && $stable(i_out_has) && $stable(i_out_last))
        else $error("output request changed while stalled");

    // the empty result closes a text
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_has |-> i_out_last)
        else $error("empty result without last flag");

    // the empty result carries codepoint zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_has |-> i_out_cp == 21'd0)
        else $error("empty result with nonzero codepoint");

    // text never ends in a space
    a_no_end_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_has && i_out_cp == 21'h20 |-> !i_out_last)
        else $error("text ends in a space");

endmodule

bind japanese_text_fold jtf_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (m_out.valid),
    .i_out_ready (m_out.ready),
    .i_out_cp    (m_out.out_code_point),
    .i_out_has   (m_out.out_has_char),
    .i_out_last  (m_out.last_of_text)
);

// File: tb/sv/tb_top.sv
// self-checking testbench of the japanese text fold block
`timescale 1ns / 1ps

module tb_top;
    import jtf_pkg::*;

    typedef struct packed {
        logic [20:0] cp;
        logic        has;
        logic        last;
    } t_out;

    typedef struct {
        logic [20:0] cp;
        logic        has;
        logic        eot;
        logic        chk;
        int          n;
        t_out        r0;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_index;
    logic [15:0] i_cfg_data;

    jtf_in_if  s_in ();
    jtf_out_if m_out ();

    japanese_text_fold dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(s_in), .m_out(m_out),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // folding state mirror
    logic        f_hira;
    logic [15:0] f_cap;
    logic [20:0] f_held;
    logic        f_held_v;
    logic        f_space;
    logic [16:0] f_bytes;
    logic        f_full;

    t_out fold_q[$];
    int   errors;
    int   cycles;
    bit   hold_off;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // cycle limit
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 600000) begin
                $display("japanese_text_fold: mismatch");
                $finish;
            end
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("error: %s got %h expected %h", what, got, exp);
        errors++;
    endtask

    function automatic int utf8_len(input logic [20:0] c);
        if (c < 21'h80) return 1;
        if (c < 21'h800) return 2;
        if (c < 21'h10000) return 3;
        return 4;
    endfunction

    function automatic logic [20:0] voiced(input logic [20:0] c);
        logic [20:0] b;
        b = (c >= 21'h30A1) ? c - 21'h60 : c;
        if (b < 21'h3041 || b > 21'h3096) return 21'd0;
        if (b == 21'h3046) return c + 21'h4E;
        if ((b >= 21'h304B && b <= 21'h3062 && b[0]) ||
            (b >= 21'h3064 && b <= 21'h3069 && !b[0])) return c + 21'd1;
        if (b >= 21'h306F && b <= 21'h307D && (b - 21'h306F) % 3 == 0) return c + 21'd1;
        return 21'd0;
    endfunction

    function automatic logic [20:0] semivoiced(input logic [20:0] c);
        logic [20:0] b;
        b = (c >= 21'h30A1) ? c - 21'h60 : c;
        if (b >= 21'h306F && b <= 21'h307D && (b - 21'h306F) % 3 == 0) return c + 21'd2;
        return 21'd0;
    endfunction

    function automatic logic [20:0] fold_case(input logic [20:0] c);
        if (c >= 21'h41 && c <= 21'h5A) return c + 21'd32;
        if (c < 21'hC0) return c;
        if (c <= 21'hDE) return (c == 21'hD7) ? c : c + 21'd32;
        if (c == 21'h178) return 21'hFF;
        if (c >= 21'h100 && c <= 21'h137) return c | 21'd1;
        if (c >= 21'h139 && c <= 21'h148) return c[0] ? c + 21'd1 : c;
        if (c >= 21'h14A && c <= 21'h177) return c | 21'd1;
        if (c >= 21'h179 && c <= 21'h17E) return c[0] ? c + 21'd1 : c;
        return c;
    endfunction

    function automatic bit is_blank(input logic [20:0] c);
        return c == 21'h20 || (c >= 21'h09 && c <= 21'h0D) || c == 21'h3000 ||
               c == 21'hA0 || (c >= 21'h2000 && c <= 21'h200A) || c == 21'h202F ||
               c == 21'h205F;
    endfunction

    function automatic void clear_text();
        f_held = 21'd0; f_held_v = 1'b0; f_space = 1'b0; f_bytes = 17'd0; f_full = 1'b0;
    endfunction

    function automatic void put_out(input logic [20:0] c, ref int k);
        fold_q.push_back('{cp: c, has: 1'b1, last: 1'b0});
        k++;
    endfunction

    function automatic void write_char(input logic [20:0] c, ref int k);
        int  need;
        bit  ws;
        need = utf8_len(c);
        if (f_held_v) begin
            put_out(f_held, k);
            f_held_v = 0;
        end
        ws = f_space && f_bytes > 0;
        f_space = 0;
        if (ws) need++;
        if (f_full || f_bytes + need >= f_cap) begin
            f_full = 1;
            return;
        end
        if (ws) put_out(21'h20, k);
        f_bytes += 17'(need);
        f_held = c;
        f_held_v = 1;
    endfunction

    function automatic void mark(input bit semi);
        logic [20:0] v;
        if (!f_held_v || f_space || f_full) return;
        v = semi ? semivoiced(f_held) : voiced(f_held);
        if (v != 0) f_held = v;
    endfunction

    function automatic void write_run(input t_run r, ref int k);
        for (int i = 0; i < r.cnt; i++) write_char(r.cp[i], k);
    endfunction

    function automatic void fold_char(input logic [20:0] c0, ref int k);
        logic [20:0] c;
        int num;
        int kind;
        c = c0;
        if (is_blank(c)) begin
            f_space = 1;
            return;
        end
        if (c == 0 || (c >= 21'h200B && c <= 21'h200D) || c == 21'hFEFF) return;
        if (c >= 21'hFF01 && c <= 21'hFF5E) c -= 21'hFEE0;
        else if (c >= 21'hFF61 && c <= 21'hFF9F) begin
            if (c >= 21'hFF9E) begin
                mark(c == 21'hFF9F);
                return;
            end
            c = {5'd0, HW_MAP[c - 21'hFF61]};
        end
        else if (c == 21'h3099 || c == 21'h309B) begin
            mark(0);
            return;
        end
        else if (c == 21'h309A || c == 21'h309C) begin
            mark(1);
            return;
        end
        else if (c == 21'h301C || c == 21'h2053) c = 21'h7E;
        else if ((c >= 21'h2010 && c <= 21'h2015) || c == 21'h2212) c = 21'h2D;
        else if (c == 21'h337F || (c >= 21'h3231 && c <= 21'h3234) || c == 21'h3236) begin
            write_run(company_run(c == 21'h337F ? 3'd0 : c == 21'h3236 ? 3'd4 :
                                  3'(c - 21'h3231)), k);
            return;
        end
        else if (c >= 21'h32A4 && c <= 21'h32A8) begin
            case (c)
                21'h32A4: write_char(21'h4E0A, k);
                21'h32A5: write_char(21'h4E2D, k);
                21'h32A6: write_char(21'h4E0B, k);
                21'h32A7: write_char(21'h5DE6, k);
                default:  write_char(21'h53F3, k);
            endcase
            return;
        end
        else if (c == 21'h2116) begin
            write_char(21'h6E, k);
            write_char(21'h6F, k);
            return;
        end
        else if (c == 21'h2121) begin
            write_char(21'h74, k);
            write_char(21'h65, k);
            write_char(21'h6C, k);
            return;
        end
        else if (c == 21'h24EA) c = 21'h30;
        else if (c >= 21'h2460 && c <= 21'h249B) begin
            num = int'((c - 21'h2460) % 20) + 1;
            kind = int'((c - 21'h2460) / 20);
            if (kind == 1) write_char(21'h28, k);
            if (num >= 10) write_char(21'(48 + num / 10), k);
            write_char(21'(48 + num % 10), k);
            if (kind == 1) write_char(21'h29, k);
            if (kind == 2) write_char(21'h2E, k);
            return;
        end
        else if (c >= 21'h2160 && c <= 21'h217F) begin
            write_run(roman_run(4'(c - 21'h2160)), k);
            return;
        end
        if (f_hira && c >= 21'h30A1 && c <= 21'h30F6) c -= 21'h60;
        if (c < 21'h180) c = fold_case(c);
        write_char(c, k);
    endfunction

    // predict the results of one request, return their count
    function automatic int fold_predict(input logic [20:0] c, input logic has,
                                        input logic eot);
        int k;
        t_out t;
        k = 0;
        if (has) fold_char(c, k);
        if (eot) begin
            if (f_held_v) begin
                put_out(f_held, k);
                f_held_v = 0;
            end
            if (k == 0) begin
                fold_q.push_back('{cp: 21'd0, has: 1'b0, last: 1'b0});
                k = 1;
            end
            t = fold_q.pop_back();
            t.last = 1'b1;
            fold_q.push_back(t);
            clear_text();
        end
        return k;
    endfunction

    // output side: random stall, long hold-off on request
    initial begin
        int gap;
        m_out.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) m_out.ready <= 1'b0;
            else begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
                      ($urandom_range(0, 3) == 0) ? 1 : 0;
                if (gap == 0) m_out.ready <= 1'b1;
                else begin
                    m_out.ready <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && m_out.valid && m_out.ready) begin
            if (fold_q.size() == 0)
                report("unexpected result", 32'(m_out.out_code_point), 32'd0);
            else begin
                e = fold_q.pop_front();
                if (m_out.out_code_point !== e.cp)
                    report("code point", 32'(m_out.out_code_point), 32'(e.cp));
                if (m_out.out_has_char !== e.has)
                    report("has char", 32'(m_out.out_has_char), 32'(e.has));
                if (m_out.last_of_text !== e.last)
                    report("last", 32'(m_out.last_of_text), 32'(e.last));
            end
        end
    end

    task automatic send(input logic [20:0] c, input logic has, input logic eot,
                        input bit gaps);
        int n;
        s_in.valid <= 1'b1;
        s_in.in_code_point <= c;
        s_in.in_has_char <= has;
        s_in.end_of_text <= eot;
        do @(posedge i_clk); while (!s_in.ready);
        n = fold_predict(c, has, eot);
        @(negedge i_clk);
        if (gaps && $urandom_range(0, 3) == 0) begin
            s_in.valid <= 1'b0;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 25) : $urandom_range(1, 2);
            repeat (n) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        s_in.valid <= 1'b0;
        while (fold_q.size() != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_KANA) f_hira = v[0];
        else f_cap = v;
    endtask

    function automatic logic [20:0] pick_cp();
        int s;
        s = $urandom_range(0, 19);
        case (s)
            0: return 21'($urandom_range(21'h30A1, 21'h30F6));
            1: return 21'($urandom_range(21'h3041, 21'h3096));
            2: return 21'($urandom_range(21'hFF61, 21'hFF9F));
            3: return 21'($urandom_range(0, 3) == 0 ? 21'hFF9F : 21'hFF9E);
            4: return 21'(21'h3099 + $urandom_range(0, 3));
            5: return 21'($urandom_range(21'hFF01, 21'hFF5E));
            6: return 21'($urandom_range(21'h2460, 21'h249B));
            7: return 21'($urandom_range(21'h2160, 21'h217F));
            8: return 21'($urandom_range(21'h3231, 21'h3236));
            9: return 21'($urandom_range(21'h32A4, 21'h32A8));
            10: return 21'($urandom_range(21'h2000, 21'h2015));
            11: return 21'($urandom_range(0, 21'h17F));
            12: return 21'($urandom_range(0, 1) ? 21'h20 : 21'h3000);
            13: return 21'($urandom_range(21'h10000, 21'h1FFFFF));
            14: begin
                case ($urandom_range(0, 7))
                    0: return 21'h2116;
                    1: return 21'h2121;
                    2: return 21'h24EA;
                    3: return 21'h337F;
                    4: return 21'h301C;
                    5: return 21'h2053;
                    6: return 21'h2212;
                    default: return 21'hFEFF;
                endcase
            end
            15: return 21'($urandom_range(21'hD800, 21'hDFFF));
            default: return 21'($urandom_range(0, 21'h1FFFFF));
        endcase
    endfunction

    // directed rows, typed expectation only for the obvious ones
    t_row dir_rows[] = '{
        '{21'h000000, 1'b0, 1'b1, 1'b1, 1, '{21'd0, 1'b0, 1'b1}},
        '{21'h000000, 1'b0, 1'b0, 1'b1, 0, '{21'd0, 1'b0, 1'b0}},
        '{21'h000020, 1'b1, 1'b0, 1'b1, 0, '{21'd0, 1'b0, 1'b0}},
        '{21'h00FF21, 1'b1, 1'b0, 1'b1, 0, '{21'd0, 1'b0, 1'b0}},
        '{21'h003000, 1'b1, 1'b0, 1'b0, 0, '{21'd0, 1'b0, 1'b0}},
        '{21'h003099, 1'b1, 1'b0, 1'b0, 0, '{21'd0, 1'b0, 1'b0}},
        '{21'h00FF76, 1'b1, 1'b0, 1'b0, 0, '{21'd0, 1'b0, 1'b0}},
        '{21'h00FF9E, 1'b1, 1'b0, 1'b0, 0, '{21'd0, 1'b0, 1'b0}},
        '{21'h0030CF, 1'b1, 1'b0, 1'b0, 0, '{21'd0, 1'b0, 1'b0}},
        '{21'h00309A, 1'b1, 1'b0, 1'b0, 0, '{21'd0, 1'b0, 1'b0}},
        '{21'h0030A6, 1'b1, 1'b0, 1'b0, 0, '{21'd0, 1'b0, 1'b0}},
        '{21'h00309B, 1'b1, 1'b0, 1'b0, 0, '{21'd0, 1'b0, 1'b0}},
        '{21'h003232, 1'b1, 1'b0, 1'b0, 0, '{21'd0, 1'b0, 1'b0}},
        '{21'h0032A8, 1'b1, 1'b0, 1'b0, 0, '{21'd0, 1'b0, 1'b0}},
        '{21'h002473, 1'b1, 1'b0, 1'b0, 0, '{21'd0, 1'b0, 1'b0}},
        '{21'h00249B, 1'b1, 1'b0, 1'b0, 0, '{21'd0, 1'b0, 1'b0}},
        '{21'h00217F, 1'b1, 1'b0, 1'b0, 0, '{21'd0, 1'b0, 1'b0}},
        '{21'h002121, 1'b1, 1'b0, 1'b0, 0, '{21'd0, 1'b0, 1'b0}},
        '{21'h00200B, 1'b1, 1'b0, 1'b0, 0, '{21'd0, 1'b0, 1'b0}},
        '{21'h000178, 1'b1, 1'b0, 1'b0, 0, '{21'd0, 1'b0, 1'b0}},
        '{21'h1FFFFF, 1'b1, 1'b0, 1'b0, 0, '{21'd0, 1'b0, 1'b0}},
        '{21'h000009, 1'b1, 1'b1, 1'b0, 0, '{21'd0, 1'b0, 1'b0}}
    };

    initial begin
        int n;
        int texts;
        int len;
        logic [20:0] c;
        t_out e;
        errors = 0;
        hold_off = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_KANA;
        i_cfg_data = 16'd0;
        s_in.valid = 1'b0;
        s_in.in_code_point = 21'd0;
        s_in.in_has_char = 1'b0;
        s_in.end_of_text = 1'b0;
        f_hira = 1'b1;
        f_cap = 16'hFFFF;
        clear_text();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed rows: the prediction of each typed row is checked against its own entry
        foreach (dir_rows[i]) begin
            send(dir_rows[i].cp, dir_rows[i].has, dir_rows[i].eot, 1'b0);
            if (dir_rows[i].chk && dir_rows[i].n == 1) begin
                e = fold_q[fold_q.size() - 1];
                if (e !== dir_rows[i].r0) report("directed row", 32'(e), 32'(dir_rows[i].r0));
            end
        end
        drain();

        // random texts over several settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(CFG_KANA, 16'd0); write_reg(CFG_CAP, 16'd1); end
                1: begin write_reg(CFG_KANA, 16'd1); write_reg(CFG_CAP, 16'd7); end
                2: begin write_reg(CFG_KANA, 16'd0); write_reg(CFG_CAP, 16'hFFFF); end
                3: begin write_reg(CFG_KANA, 16'd1); write_reg(CFG_CAP, 16'd0); end
                4: begin write_reg(CFG_KANA, 16'd1); write_reg(CFG_CAP, 16'd14); end
                default: write_reg(CFG_CAP, 16'hFFFF);
            endcase
            texts = (ph == 5) ? 12 : 4;
            for (int t = 0; t < texts; t++) begin
                len = $urandom_range(1, 8);
                if (ph == 2 && t == 1) begin
                    // long receiver hold-off so the block fills and stalls
                    len = 12;
                    hold_off = 1;
                    fork
                        begin
                            repeat (60) @(negedge i_clk);
                            hold_off = 0;
                        end
                    join_none
                end
                for (int j = 0; j < len; j++) begin
                    c = pick_cp();
                    n = $urandom_range(0, 15);
                    send(c, n != 0, j == len - 1, 1'b1);
                end
            end
            drain();
        end

        if (errors == 0) $display("japanese_text_fold: match");
        else $display("japanese_text_fold: mismatch");
        $finish;
    end

endmodule
